// ===== rtl/smv_pkg.sv =====
package smv_pkg;

    typedef enum logic [1:0] {
        FUNC_ADD_ENTRY = 2'd0,
        FUNC_WRITE_VEC = 2'd1,
        FUNC_RUN       = 2'd2,
        FUNC_CLEAR     = 2'd3
    } func_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH,
        ST_DECODE,
        ST_MUL1,
        ST_ACC1,
        ST_MUL2,
        ST_ACC2,
        ST_ORD,
        ST_OLOAD,
        ST_OSEND
    } state_t;

    localparam logic CFG_MATRIX_SIZE = 1'b0;
    localparam logic CFG_SYMMETRIC   = 1'b1;

    localparam int VAL_W   = 32;
    localparam int ACC_W   = 64;
    localparam int IDX_W   = 6;
    localparam int ENTRY_W = 2 * IDX_W + VAL_W;

    // memory and datapath controls driven by the sequencer
    typedef struct packed {
        logic store_rd;
        logic vec_rd;
        logic acc_rd;
        logic acc_wr;
        logic mul_en;
        logic mul_sel_row;
        logic acc_sel_col;
    } ctrl_t;

    function automatic logic signed [ACC_W-1:0] sat_add64(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic signed [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1]) begin
            sat_add64 = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            sat_add64 = s[ACC_W-1:0];
        end
    endfunction

    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        if (v > $signed({{(ACC_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}})) begin
            sat32 = {1'b0, {(VAL_W-1){1'b1}}};
        end else if (v < $signed({{(ACC_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}})) begin
            sat32 = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            sat32 = v[VAL_W-1:0];
        end
    endfunction

endpackage

// ===== rtl/smv_ram.sv =====
module smv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

// ===== rtl/smv_mac.sv =====
module smv_mac (
    input  logic                           aclk,
    input  logic                           mul_en,
    input  logic signed [smv_pkg::VAL_W-1:0] mul_a,
    input  logic signed [smv_pkg::VAL_W-1:0] mul_b,
    input  logic signed [smv_pkg::ACC_W-1:0] acc_in,
    output logic signed [smv_pkg::ACC_W-1:0] acc_out
);
    import smv_pkg::*;

    logic signed [ACC_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] prod_next;

    assign prod_next = ACC_W'(mul_a) * ACC_W'(mul_b);

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= prod_next;
        end
    end

    // arithmetic shift floors the Q32.32 product to Q16.16
    assign acc_out = sat_add64(acc_in, prod_reg >>> 16);
endmodule

// ===== rtl/sparse_matrix_vector_multiply.sv =====
// Channel  | Dir | Handshake          | Payload
// s_       | in  | s_tvalid/s_tready  | tuser: func; tdata: row, col, value
// m_       | out | m_tvalid/m_tready  | tdata: index, value; tlast; tuser: dropped
// cfg_     | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
// Each load (add entry, vector write, clear) is a single input beat.
// A run fetches each stored entry, skips it if out of range, else multiplies and
// accumulates it, twice for a symmetric off-diagonal entry (one shared multiplier
// and one accumulator memory port), then sends each result element, held by stalls.
// aresetn is synchronous; accumulator and vector contents are masked by valid
// flops, so no clearing pass is needed. s_tready is low for the whole run.
module sparse_matrix_vector_multiply #(
    parameter int MAX_SIZE    = 64,
    parameter int MAX_ENTRIES = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // row_index[5:0], col_index[11:6], operand_value[43:12]
    input  logic [1:0]  s_tuser,  // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // out_index[5:0], out_value[37:6]
    output logic        m_tlast,
    output logic [0:0]  m_tuser,  // entries_dropped[0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data
);
    import smv_pkg::*;

    localparam int IW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    state_t state_reg, state_next;
    ctrl_t  ctrl;

    logic [6:0]          matrix_size_reg;
    logic                symmetric_reg;
    logic [CW-1:0]       count_reg;
    logic                dropped_reg;
    logic [CW-1:0]       idx_reg;
    logic [6:0]          size_reg;
    logic [IDX_W-1:0]    er_reg, ec_reg;
    logic signed [VAL_W-1:0] ev_reg;
    logic [IDX_W-1:0]    oi_reg;
    logic [MAX_SIZE-1:0] vec_valid_reg;
    logic [MAX_SIZE-1:0] acc_valid_reg;
    logic                vc_ok_reg, vr_ok_reg, acc_ok_reg;
    logic                out_valid_reg;
    logic [IDX_W-1:0]    out_index_reg;
    logic signed [VAL_W-1:0] out_value_reg;
    logic                out_last_reg;
    logic                out_drop_reg;

    logic                in_beat, out_beat;
    func_t               func;
    logic [IDX_W-1:0]    in_row, in_col;
    logic [VAL_W-1:0]    in_val;
    logic [ENTRY_W-1:0]  store_rdata;
    logic [IDX_W-1:0]    st_row, st_col;
    logic [VAL_W-1:0]    vec_c_data, vec_r_data;
    logic [ACC_W-1:0]    acc_rdata;
    logic signed [ACC_W-1:0] acc_sum;
    logic [IW-1:0]       acc_addr;
    logic [6:0]          eff_size;
    logic                in_range;
    logic                last_elem;

    assign in_beat   = s_tvalid && s_tready;
    assign out_beat  = m_tvalid && m_tready;
    assign func      = func_t'(s_tuser);
    assign in_row    = s_tdata[5:0];
    assign in_col    = s_tdata[11:6];
    assign in_val    = s_tdata[43:12];
    assign st_row    = store_rdata[IDX_W-1:0];
    assign st_col    = store_rdata[2*IDX_W-1:IDX_W];
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_range  = ({1'b0, st_row} < size_reg) && ({1'b0, st_col} < size_reg);
    assign last_elem = (({1'b0, oi_reg} + 7'd1) == size_reg);

    always_comb begin
        if (matrix_size_reg == 7'd0) begin
            eff_size = 7'd1;
        end else if (matrix_size_reg > 7'(MAX_SIZE)) begin
            eff_size = 7'(MAX_SIZE);
        end else begin
            eff_size = matrix_size_reg;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_beat && func == FUNC_RUN) state_next = ST_FETCH;
            ST_FETCH:  state_next = (idx_reg == count_reg) ? ST_ORD : ST_DECODE;
            ST_DECODE: state_next = in_range ? ST_MUL1 : ST_FETCH;
            ST_MUL1:   state_next = ST_ACC1;
            ST_ACC1:   state_next = (symmetric_reg && er_reg != ec_reg) ? ST_MUL2 : ST_FETCH;
            ST_MUL2:   state_next = ST_ACC2;
            ST_ACC2:   state_next = ST_FETCH;
            ST_ORD:    state_next = ST_OLOAD;
            ST_OLOAD:  state_next = ST_OSEND;
            ST_OSEND: begin
                if (out_beat) begin
                    state_next = out_last_reg ? ST_IDLE : ST_ORD;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // controls
    always_comb begin
        ctrl = '0;
        case (state_reg)
            ST_FETCH:  ctrl.store_rd = (idx_reg != count_reg);
            ST_DECODE: ctrl.vec_rd = 1'b1;
            ST_MUL1: begin
                ctrl.mul_en = 1'b1;
                ctrl.acc_rd = 1'b1;
            end
            ST_ACC1:   ctrl.acc_wr = 1'b1;
            ST_MUL2: begin
                ctrl.mul_en      = 1'b1;
                ctrl.mul_sel_row = 1'b1;
                ctrl.acc_rd      = 1'b1;
                ctrl.acc_sel_col = 1'b1;
            end
            ST_ACC2: begin
                ctrl.acc_wr      = 1'b1;
                ctrl.acc_sel_col = 1'b1;
            end
            ST_ORD:    ctrl.acc_rd = 1'b1;
            default:   ctrl = '0;
        endcase
    end

    always_comb begin
        if (state_reg == ST_ORD) begin
            acc_addr = oi_reg[IW-1:0];
        end else if (ctrl.acc_sel_col) begin
            acc_addr = ec_reg[IW-1:0];
        end else begin
            acc_addr = er_reg[IW-1:0];
        end
    end

    smv_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ENTRIES)) u_store (
        .aclk    (aclk),
        .wr_en   (in_beat && func == FUNC_ADD_ENTRY && count_reg < CW'(MAX_ENTRIES)),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data ({in_val, in_col, in_row}),
        .rd_en   (ctrl.store_rd),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (store_rdata)
    );

    // two copies give the column and row element in the same cycle
    smv_ram #(.WIDTH(VAL_W), .DEPTH(MAX_SIZE)) u_vec_c (
        .aclk    (aclk),
        .wr_en   (in_beat && func == FUNC_WRITE_VEC && {1'b0, in_row} < 7'(MAX_SIZE)),
        .wr_addr (in_row[IW-1:0]),
        .wr_data (in_val),
        .rd_en   (ctrl.vec_rd),
        .rd_addr (st_col[IW-1:0]),
        .rd_data (vec_c_data)
    );

    smv_ram #(.WIDTH(VAL_W), .DEPTH(MAX_SIZE)) u_vec_r (
        .aclk    (aclk),
        .wr_en   (in_beat && func == FUNC_WRITE_VEC && {1'b0, in_row} < 7'(MAX_SIZE)),
        .wr_addr (in_row[IW-1:0]),
        .wr_data (in_val),
        .rd_en   (ctrl.vec_rd),
        .rd_addr (st_row[IW-1:0]),
        .rd_data (vec_r_data)
    );

    smv_ram #(.WIDTH(ACC_W), .DEPTH(MAX_SIZE)) u_acc (
        .aclk    (aclk),
        .wr_en   (ctrl.acc_wr),
        .wr_addr (acc_addr),
        .wr_data (acc_sum),
        .rd_en   (ctrl.acc_rd),
        .rd_addr (acc_addr),
        .rd_data (acc_rdata)
    );

    smv_mac u_mac (
        .aclk    (aclk),
        .mul_en  (ctrl.mul_en),
        .mul_a   (ev_reg),
        .mul_b   (ctrl.mul_sel_row ? (vr_ok_reg ? vec_r_data : '0)
                                   : (vc_ok_reg ? vec_c_data : '0)),
        .acc_in  (acc_ok_reg ? acc_rdata : '0),
        .acc_out (acc_sum)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            matrix_size_reg <= 7'd64;
            symmetric_reg   <= 1'b0;
            count_reg       <= '0;
            dropped_reg     <= 1'b0;
            vec_valid_reg   <= '0;
            acc_valid_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_MATRIX_SIZE: matrix_size_reg <= cfg_data;
                    CFG_SYMMETRIC:   symmetric_reg   <= cfg_data[0];
                    default:         symmetric_reg   <= symmetric_reg;
                endcase
            end
            if (in_beat) begin
                case (func)
                    FUNC_ADD_ENTRY: begin
                        if (count_reg < CW'(MAX_ENTRIES)) begin
                            count_reg <= count_reg + CW'(1);
                        end else begin
                            dropped_reg <= 1'b1;
                        end
                    end
                    FUNC_WRITE_VEC: begin
                        if ({1'b0, in_row} < 7'(MAX_SIZE)) begin
                            vec_valid_reg[in_row[IW-1:0]] <= 1'b1;
                        end
                    end
                    FUNC_RUN:       acc_valid_reg <= '0;
                    FUNC_CLEAR: begin
                        count_reg   <= '0;
                        dropped_reg <= 1'b0;
                    end
                    default:        count_reg <= count_reg;
                endcase
            end
            if (ctrl.acc_wr) begin
                acc_valid_reg[acc_addr] <= 1'b1;
            end
            if (state_reg == ST_OLOAD) begin
                out_valid_reg <= 1'b1;
            end else if (out_beat) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_beat && func == FUNC_RUN) begin
            idx_reg  <= '0;
            oi_reg   <= '0;
            size_reg <= eff_size;
        end
        if (state_reg == ST_DECODE) begin
            er_reg    <= st_row;
            ec_reg    <= st_col;
            ev_reg    <= store_rdata[ENTRY_W-1:2*IDX_W];
            vc_ok_reg <= vec_valid_reg[st_col[IW-1:0]];
            vr_ok_reg <= vec_valid_reg[st_row[IW-1:0]];
            if (!in_range) begin
                idx_reg <= idx_reg + CW'(1);
            end
        end
        if (ctrl.acc_rd) begin
            acc_ok_reg <= acc_valid_reg[acc_addr];
        end
        if ((state_reg == ST_ACC1 && !(symmetric_reg && er_reg != ec_reg))
            || state_reg == ST_ACC2) begin
            idx_reg <= idx_reg + CW'(1);
        end
        if (state_reg == ST_OLOAD) begin
            out_index_reg <= oi_reg;
            out_value_reg <= sat32(acc_ok_reg ? acc_rdata : '0);
            out_last_reg  <= last_elem;
            out_drop_reg  <= dropped_reg;
        end
        if (state_reg == ST_OSEND && out_beat) begin
            oi_reg <= oi_reg + IDX_W'(1);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_value_reg, out_index_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_drop_reg;
endmodule

// ===== rtl/smv_checker.sv =====
module smv_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tlast
);
    import smv_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_tvalid && s_tready))
        else $error("input taken while result pending");

    a_run_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == FUNC_RUN |=> !s_tready)
        else $error("input ready right after run start");

    a_last_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid)
        else $error("result after last beat");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");
endmodule

bind sparse_matrix_vector_multiply smv_checker u_smv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== test/sparse_matrix_vector_multiply_tb.sv =====
`timescale 1ns / 100ps

module sparse_matrix_vector_multiply_tb;
    import smv_pkg::*;

    localparam int N_SIZE    = 64;
    localparam int N_ENTRIES = 1024;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int SETTLE = 40;

    typedef struct {
        logic [5:0]  index;
        logic [31:0] value;
        logic        last;
        logic        dropped;
    } elem_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;
    logic [0:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [6:0]  cfg_data;

    // mirror of the block's state
    logic [5:0]         store_row [N_ENTRIES];
    logic [5:0]         store_col [N_ENTRIES];
    logic signed [31:0] store_val [N_ENTRIES];
    int                 store_fill;
    logic signed [31:0] in_vec [N_SIZE];
    logic               dropped_flag;
    logic [6:0]         size_reg;
    logic               sym_reg;

    elem_t result_q[$];
    int    mismatches;
    int    cycles;
    bit    quiet;

    sparse_matrix_vector_multiply i_dut (.*);

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("sparse_matrix_vector_multiply_tb NOT OK");
            $finish;
        end
    end

    // result side back-pressure in short bursts
    int stall_left;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b1;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= (stall_left == 1);
        end else if (!quiet && $urandom_range(3) == 0) begin
            stall_left <= $urandom_range(4, 1);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        elem_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (result_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat idx=%0d val=%h", m_tdata[5:0], m_tdata[37:6]);
            end else begin
                want = result_q.pop_front();
                if (m_tdata[5:0] !== want.index || m_tdata[37:6] !== want.value ||
                    m_tlast !== want.last || m_tuser[0] !== want.dropped) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp idx=%0d val=%h last=%b drop=%b got idx=%0d val=%h last=%b drop=%b",
                                 want.index, want.value, want.last, want.dropped,
                                 m_tdata[5:0], m_tdata[37:6], m_tlast, m_tuser[0]);
                end
            end
        end
    end

    function automatic logic signed [63:0] acc_add(logic signed [63:0] a, logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7fff_ffff_ffff_ffff;
        return s[63:0];
    endfunction

    // Q16.16 product, floored
    function automatic logic signed [63:0] q16_mul(logic signed [31:0] a, logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return p >>> 16;
    endfunction

    task automatic predict_product();
        logic signed [63:0] acc [N_SIZE];
        int    eff;
        elem_t e;
        eff = (size_reg == 0) ? 1 : (size_reg > N_SIZE) ? N_SIZE : size_reg;
        foreach (acc[i]) acc[i] = 0;
        for (int i = 0; i < store_fill; i++) begin
            if (store_row[i] < eff && store_col[i] < eff) begin
                acc[store_row[i]] = acc_add(acc[store_row[i]],
                                            q16_mul(store_val[i], in_vec[store_col[i]]));
                if (sym_reg && store_row[i] != store_col[i])
                    acc[store_col[i]] = acc_add(acc[store_col[i]],
                                                q16_mul(store_val[i], in_vec[store_row[i]]));
            end
        end
        for (int i = 0; i < eff; i++) begin
            e.index   = i[5:0];
            e.value   = (acc[i] > 64'sh7fff_ffff) ? 32'h7fff_ffff :
                        (acc[i] < -64'sh8000_0000) ? 32'h8000_0000 : acc[i][31:0];
            e.last    = (i == eff - 1);
            e.dropped = dropped_flag;
            result_q.push_back(e);
        end
    endtask

    task automatic send_item(func_t f, logic [5:0] r, logic [5:0] c, logic [31:0] v);
        if (!quiet && $urandom_range(4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {4'b0, v, c, r};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        case (f)
            FUNC_ADD_ENTRY: begin
                if (store_fill < N_ENTRIES) begin
                    store_row[store_fill] = r;
                    store_col[store_fill] = c;
                    store_val[store_fill] = v;
                    store_fill++;
                end else begin
                    dropped_flag = 1'b1;
                end
            end
            FUNC_WRITE_VEC: in_vec[r] = v;
            FUNC_CLEAR: begin
                store_fill   = 0;
                dropped_flag = 1'b0;
            end
            default: predict_product();
        endcase
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (result_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [6:0] data);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_MATRIX_SIZE) size_reg = data;
        else sym_reg = data[0];
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(3))
            0: return $urandom();
            1: return $urandom_range(32'h3ffff);
            2: return -$urandom_range(32'h3ffff);
            default: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
        endcase
    endfunction

    function automatic logic [5:0] pick_index(int lim);
        if ($urandom_range(9) < 8) return $urandom_range(lim - 1);
        return $urandom_range(63);
    endfunction

    task automatic test_directed();
        send_item(FUNC_WRITE_VEC, 0, 0, 32'h7fff_ffff);
        send_item(FUNC_WRITE_VEC, 63, 0, 32'h8000_0000);
        send_item(FUNC_WRITE_VEC, 5, 0, 32'hffff_ffff);
        send_item(FUNC_WRITE_VEC, 7, 0, 32'h0001_0000);
        send_item(FUNC_ADD_ENTRY, 0, 63, 32'h8000_0000);
        send_item(FUNC_ADD_ENTRY, 63, 0, 32'h7fff_ffff);
        send_item(FUNC_ADD_ENTRY, 63, 63, 32'h8000_0000);
        send_item(FUNC_ADD_ENTRY, 5, 5, 32'h0001_0000);
        send_item(FUNC_ADD_ENTRY, 3, 7, 32'hfffe_8000);  // above the diagonal
        send_item(FUNC_ADD_ENTRY, 7, 5, 32'h0000_0001);
        send_item(FUNC_RUN, 0, 0, 0);
        write_reg(CFG_SYMMETRIC, 7'd1);
        send_item(FUNC_RUN, 0, 0, 0);
        write_reg(CFG_MATRIX_SIZE, 7'd6);              // drops entries past row or column 5
        send_item(FUNC_RUN, 0, 0, 0);
        write_reg(CFG_MATRIX_SIZE, 7'd0);              // acts as one
        send_item(FUNC_RUN, 0, 0, 0);
        write_reg(CFG_MATRIX_SIZE, 7'd127);            // clamps to full size
        send_item(FUNC_RUN, 0, 0, 0);
        send_item(FUNC_CLEAR, 0, 0, 0);
        send_item(FUNC_RUN, 0, 0, 0);
    endtask

    task automatic test_store_full();
        write_reg(CFG_MATRIX_SIZE, 7'd4);
        for (int i = 0; i < N_ENTRIES + 3; i++)
            send_item(FUNC_ADD_ENTRY, $urandom_range(5), $urandom_range(5), pick_value());
        send_item(FUNC_RUN, 0, 0, 0);
        send_item(FUNC_CLEAR, 0, 0, 0);
        send_item(FUNC_RUN, 0, 0, 0);
    endtask

    task automatic test_random(int n, int lim);
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(99);
            if (i == n / 2) drain();
            if (k < 50)
                send_item(FUNC_ADD_ENTRY, pick_index(lim), pick_index(lim), pick_value());
            else if (k < 85)
                send_item(FUNC_WRITE_VEC, pick_index(lim), $urandom_range(63), pick_value());
            else if (k < 96)
                send_item(FUNC_RUN, $urandom_range(63), $urandom_range(63), $urandom());
            else
                send_item(FUNC_CLEAR, $urandom_range(63), $urandom_range(63), $urandom());
        end
    endtask

    task automatic test_settings();
        write_reg(CFG_MATRIX_SIZE, 7'd64);
        write_reg(CFG_SYMMETRIC, 7'd0);
        test_random(110, 64);
        write_reg(CFG_MATRIX_SIZE, 7'd1);
        write_reg(CFG_SYMMETRIC, 7'd1);
        test_random(60, 1);
        write_reg(CFG_MATRIX_SIZE, 7'd9);
        test_random(120, 9);
        quiet = 1'b1;
        write_reg(CFG_MATRIX_SIZE, 7'd20);
        write_reg(CFG_SYMMETRIC, 7'd0);
        test_random(120, 20);
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_index = 1'b0;
        cfg_data  = '0;
        cycles = 0;
        mismatches = 0;
        quiet = 1'b0;
        store_fill = 0;
        dropped_flag = 1'b0;
        size_reg = 7'd64;
        sym_reg = 1'b0;
        foreach (in_vec[i]) in_vec[i] = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_store_full();
        test_settings();
        drain();
        if (mismatches == 0 && result_q.size() == 0) begin
            $display("sparse_matrix_vector_multiply_tb OK");
        end else begin
            $display("sparse_matrix_vector_multiply_tb NOT OK");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/smv_pkg.sv
rtl/smv_ram.sv
rtl/smv_mac.sv
rtl/sparse_matrix_vector_multiply.sv
rtl/smv_checker.sv
test/sparse_matrix_vector_multiply_tb.sv
